// ----- sv/pmo_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmo_pkg
// shared types, constants and job tables of the polyline miter offsetter
// ----------------------------------------------------------------------------
package pmo_pkg;

   localparam int COORD_W    = 24;
   localparam int WT_W       = 23;
   localparam int UNIT_W     = 16;
   localparam int IDX_W      = 16;
   localparam int MAX_POINTS = 65536;
   localparam int SEEN_W     = $clog2(MAX_POINTS + 1);
   localparam int DOT_MIN    = 2684355;
   localparam int CSR_AW     = 3;

   typedef enum logic [4:0] {
      S_IDLE, S_PLAN, S_JOB, S_U_LOAD, S_U_NORM, S_U_SQ1, S_U_SQ2, S_U_SQRT,
      S_DX_LOAD, S_DIVX, S_DY_LOAD, S_DIVY, S_U_STORE, S_DOT1, S_DOT2, S_MCHK,
      S_MDIV_LOAD, S_DIVM, S_LEN_DIV, S_LEN_WT, S_SCX, S_SCY, S_PUT, S_NEXT,
      S_COMMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_JOB_START, OP_U_LOAD, OP_U_NORM, OP_U_SQ1, OP_U_SQ2,
      OP_SQRT_STEP, OP_DX_LOAD, OP_DIV_STEP, OP_DY_LOAD, OP_U_STORE, OP_DOT1,
      OP_DOT2, OP_MDIV_LOAD, OP_LEN_DIV, OP_LEN_WT, OP_SCX, OP_SCY, OP_PUT,
      OP_COMMIT
   } op_type;

   typedef enum logic [2:0] {
      PT_FIRST, PT_SECOND, PT_OLDER, PT_NEWER, PT_CUR
   } pt_sel_type;

   typedef enum logic [1:0] {IDX_ZERO, IDX_ONE, IDX_KM1, IDX_K} idx_sel_type;

   typedef enum logic {JOB_END, JOB_MITER} kind_type;

   typedef enum logic [2:0] {
      PLAN_NONE, PLAN_OPEN_START, PLAN_OPEN_PAIR, PLAN_CLOSED_PAIR, PLAN_MID,
      PLAN_OPEN_END, PLAN_CLOSED_END
   } plan_type;

   typedef enum logic {REG_WALL_THICKNESS, REG_CLOSED_LOOP} reg_type;

   typedef struct packed {
      kind_type    kind;
      pt_sel_type  pa;
      pt_sel_type  pb;
      pt_sel_type  pc;
      pt_sel_type  pv;
      idx_sel_type idx;
      logic        last;
   } job_type;

   typedef struct packed {
      op_type     op;
      job_type    job;
      logic [1:0] unit;
   } cmd_type;

   typedef struct packed {
      logic seen_zero;
      logic seen_one;
      logic last;
      logic ok;
      logic norm_done;
      logic sqrt_last;
      logic div_last;
      logic dot_big;
      logic out_free;
   } status_type;

   function automatic logic [1:0] jobs_of(plan_type plan);
      logic [1:0] n;
      unique case (plan)
         PLAN_OPEN_START, PLAN_MID:         n = 2'd1;
         PLAN_OPEN_PAIR, PLAN_CLOSED_PAIR,
         PLAN_OPEN_END:                     n = 2'd2;
         PLAN_CLOSED_END:                   n = 2'd3;
         default:                           n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic job_type mk_job(kind_type k, pt_sel_type a, pt_sel_type b,
                                      pt_sel_type c, pt_sel_type v,
                                      idx_sel_type i, logic l);
      job_type j;
      j.kind = k;
      j.pa   = a;
      j.pb   = b;
      j.pc   = c;
      j.pv   = v;
      j.idx  = i;
      j.last = l;
      return j;
   endfunction

   function automatic job_type job_of(plan_type plan, logic [1:0] n);
      job_type j;
      j = mk_job(JOB_MITER, PT_OLDER, PT_NEWER, PT_CUR, PT_NEWER, IDX_KM1, 1'b0);
      unique case (plan)
         PLAN_OPEN_START:
            j = mk_job(JOB_END, PT_FIRST, PT_CUR, PT_CUR, PT_FIRST, IDX_ZERO, 1'b0);
         PLAN_OPEN_PAIR:
            if (n == 2'd0) begin
               j = mk_job(JOB_END, PT_FIRST, PT_CUR, PT_CUR, PT_FIRST, IDX_ZERO, 1'b0);
            end else begin
               j = mk_job(JOB_END, PT_FIRST, PT_CUR, PT_CUR, PT_CUR, IDX_ONE, 1'b1);
            end
         PLAN_CLOSED_PAIR:
            if (n == 2'd0) begin
               j = mk_job(JOB_MITER, PT_CUR, PT_FIRST, PT_CUR, PT_FIRST, IDX_ZERO, 1'b0);
            end else begin
               j = mk_job(JOB_MITER, PT_FIRST, PT_CUR, PT_FIRST, PT_CUR, IDX_ONE, 1'b1);
            end
         PLAN_OPEN_END:
            if (n != 2'd0) begin
               j = mk_job(JOB_END, PT_NEWER, PT_CUR, PT_CUR, PT_CUR, IDX_K, 1'b1);
            end
         PLAN_CLOSED_END:
            if (n == 2'd1) begin
               j = mk_job(JOB_MITER, PT_NEWER, PT_CUR, PT_FIRST, PT_CUR, IDX_K, 1'b0);
            end else if (n == 2'd2) begin
               j = mk_job(JOB_MITER, PT_CUR, PT_FIRST, PT_SECOND, PT_FIRST, IDX_ZERO,
                          1'b1);
            end
         default: ;
      endcase
      return j;
   endfunction

endpackage
`default_nettype wire

// ----- sv/polyline_miter_offset.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_miter_offset
// outer and inner wall points of a polyline with miter joins
// ----------------------------------------------------------------------------
// Points enter on the req_ stream, one per transfer, with req_tlast on the
// final point of a polyline. Each vertex leaves on the rsp_ stream as one
// transfer holding its outer and inner offset points and its index; rsp_tuser
// flags a zero offset from a zero-length direction and rsp_tlast marks the
// final result of the polyline. wall_thickness and closed_loop sit on the
// csr_ port at byte addresses 0 and 4.
// Points are handled one at a time. The time of each result is set by the
// shared unit-vector normalizer: a shift-until-normalized loop, a 26-step
// square root and 32-step divides. An end cap takes one normalization, an
// interior join three normalizations and at most one miter divide. A
// closing point with wrap-around joins costs up to three joins.
// The result register lets the next point start while a result waits; when
// the receiver stalls, work halts at the next result until it is taken.
// Reset empties the window, drops any pending result and restores the
// registers to a thickness of 256 and open mode.
// ----------------------------------------------------------------------------
module polyline_miter_offset (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [47:0]                req_tdata,  // point_x, point_y
   input  wire logic                       req_tlast,
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [111:0]               rsp_tdata,  // outer_x, outer_y, inner_x,
                                                       // inner_y, vertex_index
   output      logic                       rsp_tlast,
   output      logic                       rsp_tuser,  // degenerate
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [pmo_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output      logic [31:0]                csr_prdata,
   output      logic                       csr_pready
);

   logic [pmo_pkg::WT_W-1:0] wall_thickness;
   logic                     closed_loop;
   pmo_pkg::cmd_type         cmd;
   pmo_pkg::status_type      sts;

   pmo_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .wall_thickness (wall_thickness),
      .closed_loop    (closed_loop)
   );

   pmo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .closed_loop (closed_loop),
      .sts         (sts),
      .cmd         (cmd)
   );

   pmo_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .wall_thickness (wall_thickness),
      .cmd            (cmd),
      .sts            (sts)
   );

   a_one_point: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("point accepted while one is in work");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:0] == rsp_tdata[95:48])
      else $error("degenerate result with nonzero offset");

   a_put_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pmo_pkg::OP_PUT |=> rsp_tvalid)
      else $error("result load did not raise valid");

endmodule
`default_nettype wire

// ----- sv/pmo_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmo_csr
// configuration registers behind the register port
// ----------------------------------------------------------------------------
module pmo_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [pmo_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output      logic [31:0]                  csr_prdata,
   output      logic                         csr_pready,
   output      logic [pmo_pkg::WT_W-1:0]     wall_thickness,
   output      logic                         closed_loop
);

   logic [pmo_pkg::WT_W-1:0] wt_ff;
   logic                     closed_ff;
   logic                     wr;
   pmo_pkg::reg_type         sel;

   assign csr_pready     = 1'b1;
   assign wr             = csr_psel & csr_penable & csr_pwrite;
   assign sel            = pmo_pkg::reg_type'(csr_paddr[2]);
   assign wall_thickness = wt_ff;
   assign closed_loop    = closed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ff     <= pmo_pkg::WT_W'(256);
         closed_ff <= 1'b0;
      end else if (wr) begin
         unique case (sel)
            pmo_pkg::REG_WALL_THICKNESS: wt_ff     <= csr_pwdata[pmo_pkg::WT_W-1:0];
            pmo_pkg::REG_CLOSED_LOOP:    closed_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         pmo_pkg::REG_WALL_THICKNESS: csr_prdata = {{(32-pmo_pkg::WT_W){1'b0}}, wt_ff};
         pmo_pkg::REG_CLOSED_LOOP:    csr_prdata = {31'b0, closed_ff};
         default:                     csr_prdata = 32'b0;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/pmo_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmo_ctrl
// sequencer: plans the joins of each point and steps the shared units
// ----------------------------------------------------------------------------
module pmo_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic                closed_loop,
   input  wire pmo_pkg::status_type sts,
   output      pmo_pkg::cmd_type    cmd
);

   pmo_pkg::state_type state_ff, state_in;
   pmo_pkg::plan_type  plan_ff, plan_in;
   logic [1:0]         job_ff, job_in;
   logic [1:0]         unit_ff, unit_in;
   pmo_pkg::job_type   job;

   assign job = pmo_pkg::job_of(plan_ff, job_ff);

   always_comb begin
      if (sts.seen_zero) begin
         plan_in = pmo_pkg::PLAN_NONE;
      end else if (sts.seen_one) begin
         if (closed_loop) begin
            plan_in = sts.last ? pmo_pkg::PLAN_CLOSED_PAIR : pmo_pkg::PLAN_NONE;
         end else begin
            plan_in = sts.last ? pmo_pkg::PLAN_OPEN_PAIR : pmo_pkg::PLAN_OPEN_START;
         end
      end else if (sts.last) begin
         plan_in = closed_loop ? pmo_pkg::PLAN_CLOSED_END : pmo_pkg::PLAN_OPEN_END;
      end else begin
         plan_in = pmo_pkg::PLAN_MID;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      unit_in  = unit_ff;
      unique case (state_ff)
         pmo_pkg::S_IDLE:      if (req_tvalid) state_in = pmo_pkg::S_PLAN;
         pmo_pkg::S_PLAN: begin
            job_in   = 2'd0;
            state_in = (pmo_pkg::jobs_of(plan_in) == 2'd0) ? pmo_pkg::S_COMMIT
                                                            : pmo_pkg::S_JOB;
         end
         pmo_pkg::S_JOB: begin
            unit_in  = 2'd0;
            state_in = pmo_pkg::S_U_LOAD;
         end
         pmo_pkg::S_U_LOAD:    state_in = pmo_pkg::S_U_NORM;
         pmo_pkg::S_U_NORM: begin
            if (!sts.ok) begin
               state_in = pmo_pkg::S_PUT;
            end else if (sts.norm_done) begin
               state_in = pmo_pkg::S_U_SQ1;
            end
         end
         pmo_pkg::S_U_SQ1:     state_in = pmo_pkg::S_U_SQ2;
         pmo_pkg::S_U_SQ2:     state_in = pmo_pkg::S_U_SQRT;
         pmo_pkg::S_U_SQRT:    if (sts.sqrt_last) state_in = pmo_pkg::S_DX_LOAD;
         pmo_pkg::S_DX_LOAD:   state_in = pmo_pkg::S_DIVX;
         pmo_pkg::S_DIVX:      if (sts.div_last) state_in = pmo_pkg::S_DY_LOAD;
         pmo_pkg::S_DY_LOAD:   state_in = pmo_pkg::S_DIVY;
         pmo_pkg::S_DIVY:      if (sts.div_last) state_in = pmo_pkg::S_U_STORE;
         pmo_pkg::S_U_STORE: begin
            if (job.kind == pmo_pkg::JOB_END) begin
               state_in = pmo_pkg::S_LEN_WT;
            end else if (unit_ff == 2'd2) begin
               state_in = pmo_pkg::S_DOT1;
            end else begin
               unit_in  = unit_ff + 2'd1;
               state_in = pmo_pkg::S_U_LOAD;
            end
         end
         pmo_pkg::S_DOT1:      state_in = pmo_pkg::S_DOT2;
         pmo_pkg::S_DOT2:      state_in = pmo_pkg::S_MCHK;
         pmo_pkg::S_MCHK:      state_in = sts.dot_big ? pmo_pkg::S_MDIV_LOAD
                                                      : pmo_pkg::S_LEN_WT;
         pmo_pkg::S_MDIV_LOAD: state_in = pmo_pkg::S_DIVM;
         pmo_pkg::S_DIVM:      if (sts.div_last) state_in = pmo_pkg::S_LEN_DIV;
         pmo_pkg::S_LEN_DIV:   state_in = pmo_pkg::S_SCX;
         pmo_pkg::S_LEN_WT:    state_in = pmo_pkg::S_SCX;
         pmo_pkg::S_SCX:       state_in = pmo_pkg::S_SCY;
         pmo_pkg::S_SCY:       state_in = pmo_pkg::S_PUT;
         pmo_pkg::S_PUT:       if (sts.out_free) state_in = pmo_pkg::S_NEXT;
         pmo_pkg::S_NEXT: begin
            if (job_ff + 2'd1 < pmo_pkg::jobs_of(plan_ff)) begin
               job_in   = job_ff + 2'd1;
               state_in = pmo_pkg::S_JOB;
            end else begin
               state_in = pmo_pkg::S_COMMIT;
            end
         end
         pmo_pkg::S_COMMIT:    state_in = pmo_pkg::S_IDLE;
         default:              state_in = pmo_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.job    = job;
      cmd.unit   = unit_ff;
      req_tready = (state_ff == pmo_pkg::S_IDLE);
      unique case (state_ff)
         pmo_pkg::S_IDLE:      cmd.op = req_tvalid ? pmo_pkg::OP_ACCEPT : pmo_pkg::OP_NONE;
         pmo_pkg::S_JOB:       cmd.op = pmo_pkg::OP_JOB_START;
         pmo_pkg::S_U_LOAD:    cmd.op = pmo_pkg::OP_U_LOAD;
         pmo_pkg::S_U_NORM:    cmd.op = pmo_pkg::OP_U_NORM;
         pmo_pkg::S_U_SQ1:     cmd.op = pmo_pkg::OP_U_SQ1;
         pmo_pkg::S_U_SQ2:     cmd.op = pmo_pkg::OP_U_SQ2;
         pmo_pkg::S_U_SQRT:    cmd.op = pmo_pkg::OP_SQRT_STEP;
         pmo_pkg::S_DX_LOAD:   cmd.op = pmo_pkg::OP_DX_LOAD;
         pmo_pkg::S_DIVX, pmo_pkg::S_DIVY,
         pmo_pkg::S_DIVM:      cmd.op = pmo_pkg::OP_DIV_STEP;
         pmo_pkg::S_DY_LOAD:   cmd.op = pmo_pkg::OP_DY_LOAD;
         pmo_pkg::S_U_STORE:   cmd.op = pmo_pkg::OP_U_STORE;
         pmo_pkg::S_DOT1:      cmd.op = pmo_pkg::OP_DOT1;
         pmo_pkg::S_DOT2:      cmd.op = pmo_pkg::OP_DOT2;
         pmo_pkg::S_MDIV_LOAD: cmd.op = pmo_pkg::OP_MDIV_LOAD;
         pmo_pkg::S_LEN_DIV:   cmd.op = pmo_pkg::OP_LEN_DIV;
         pmo_pkg::S_LEN_WT:    cmd.op = pmo_pkg::OP_LEN_WT;
         pmo_pkg::S_SCX:       cmd.op = pmo_pkg::OP_SCX;
         pmo_pkg::S_SCY:       cmd.op = pmo_pkg::OP_SCY;
         pmo_pkg::S_PUT:       cmd.op = sts.out_free ? pmo_pkg::OP_PUT : pmo_pkg::OP_NONE;
         pmo_pkg::S_COMMIT:    cmd.op = pmo_pkg::OP_COMMIT;
         default:              cmd.op = pmo_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmo_pkg::S_IDLE;
         plan_ff  <= pmo_pkg::PLAN_NONE;
         job_ff   <= 2'd0;
         unit_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         unit_ff  <= unit_in;
         if (state_ff == pmo_pkg::S_PLAN) plan_ff <= plan_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/pmo_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmo_dp
// point window, shared normalizer, square root, divider and output register
// ----------------------------------------------------------------------------
module pmo_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [47:0]                   req_tdata,
   input  wire logic                          req_tlast,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [111:0]                  rsp_tdata,
   output      logic                          rsp_tlast,
   output      logic                          rsp_tuser,
   input  wire logic [pmo_pkg::WT_W-1:0]      wall_thickness,
   input  wire pmo_pkg::cmd_type              cmd,
   output      pmo_pkg::status_type           sts
);

   localparam int CW = pmo_pkg::COORD_W;
   localparam int UW = pmo_pkg::UNIT_W;

   typedef logic signed [CW-1:0] crd_type;
   typedef logic signed [UW-1:0] unt_type;

   crd_type first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   crd_type older_x_ff, older_y_ff, newer_x_ff, newer_y_ff, cur_x_ff, cur_y_ff;
   logic    last_ff;
   logic [pmo_pkg::SEEN_W-1:0] seen_ff;

   logic [24:0] ux_ff, uy_ff;
   logic        negx_ff, negy_ff, ok_ff;
   logic [51:0] v_ff, r_ff, b_ff;
   logic [51:0] rem_ff;
   logic [60:0] den_ff;
   logic [31:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic [UW-1:0] qx_ff;
   unt_type d0x_ff, d0y_ff, d1x_ff, d1y_ff, mx_ff, my_ff;
   logic signed [31:0] dot_ff;
   logic [24:0] len_ff;
   logic signed [26:0] offx_ff, offy_ff;

   logic        out_v_ff;
   crd_type     ox_ff, oy_ff, ix_ff, iy_ff;
   logic [pmo_pkg::IDX_W-1:0] idx_ff;
   logic        degen_ff, olast_ff;

   function automatic crd_type px(pmo_pkg::pt_sel_type s, crd_type f, crd_type sc,
                                  crd_type o, crd_type n, crd_type c);
      crd_type r;
      unique case (s)
         pmo_pkg::PT_FIRST:  r = f;
         pmo_pkg::PT_SECOND: r = sc;
         pmo_pkg::PT_OLDER:  r = o;
         pmo_pkg::PT_NEWER:  r = n;
         default:            r = c;
      endcase
      return r;
   endfunction

   function automatic logic signed [26:0] scale(unt_type c, logic [24:0] len);
      logic [UW-1:0] mag;
      logic [40:0]   prod;
      logic [25:0]   r;
      mag  = c[UW-1] ? UW'(-c) : UW'(c);
      prod = 41'(mag) * 41'(len);
      r    = 26'((prod + 41'd16384) >> 15);
      return c[UW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

   function automatic crd_type sat24(logic signed [27:0] v);
      crd_type r;
      if (v > 28'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -28'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   crd_type pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pv_x, pv_y;
   logic signed [24:0] vx, vy;
   logic [24:0] umax;
   logic [51:0] rb;
   logic [60:0] rem_ext;
   logic signed [27:0] ox_s, oy_s, ix_s, iy_s;
   unt_type sc_x, sc_y, qx_s, qy_s;
   logic [24:0] wt3;
   logic [pmo_pkg::IDX_W-1:0] idx_sel;
   logic seen_max;

   assign pa_x = px(cmd.job.pa, first_x_ff, second_x_ff, older_x_ff, newer_x_ff, cur_x_ff);
   assign pa_y = px(cmd.job.pa, first_y_ff, second_y_ff, older_y_ff, newer_y_ff, cur_y_ff);
   assign pb_x = px(cmd.job.pb, first_x_ff, second_x_ff, older_x_ff, newer_x_ff, cur_x_ff);
   assign pb_y = px(cmd.job.pb, first_y_ff, second_y_ff, older_y_ff, newer_y_ff, cur_y_ff);
   assign pc_x = px(cmd.job.pc, first_x_ff, second_x_ff, older_x_ff, newer_x_ff, cur_x_ff);
   assign pc_y = px(cmd.job.pc, first_y_ff, second_y_ff, older_y_ff, newer_y_ff, cur_y_ff);
   assign pv_x = px(cmd.job.pv, first_x_ff, second_x_ff, older_x_ff, newer_x_ff, cur_x_ff);
   assign pv_y = px(cmd.job.pv, first_y_ff, second_y_ff, older_y_ff, newer_y_ff, cur_y_ff);

   always_comb begin
      case (cmd.unit)
         2'd0: begin
            vx = 25'(pb_x) - 25'(pa_x);
            vy = 25'(pb_y) - 25'(pa_y);
         end
         2'd1: begin
            vx = 25'(pc_x) - 25'(pb_x);
            vy = 25'(pc_y) - 25'(pb_y);
         end
         default: begin
            vx = -25'(d0y_ff) - 25'(d1y_ff);
            vy = 25'(d0x_ff) + 25'(d1x_ff);
         end
      endcase
   end

   assign umax    = (ux_ff > uy_ff) ? ux_ff : uy_ff;
   assign rb      = r_ff + b_ff;
   assign rem_ext = {9'b0, rem_ff};
   assign sc_x    = (cmd.job.kind == pmo_pkg::JOB_END) ? -d0y_ff : mx_ff;
   assign sc_y    = (cmd.job.kind == pmo_pkg::JOB_END) ? d0x_ff : my_ff;
   assign qx_s    = negx_ff ? -$signed(qx_ff) : $signed(qx_ff);
   assign qy_s    = negy_ff ? -$signed(quo_ff[UW-1:0]) : $signed(quo_ff[UW-1:0]);
   assign wt3     = 25'(wall_thickness) + {1'b0, wall_thickness, 1'b0};
   assign ox_s    = 28'(pv_x) + 28'(offx_ff);
   assign oy_s    = 28'(pv_y) + 28'(offy_ff);
   assign ix_s    = 28'(pv_x) - 28'(offx_ff);
   assign iy_s    = 28'(pv_y) - 28'(offy_ff);
   assign seen_max = (seen_ff == pmo_pkg::SEEN_W'(pmo_pkg::MAX_POINTS));

   always_comb begin
      case (cmd.job.idx)
         pmo_pkg::IDX_ZERO: idx_sel = '0;
         pmo_pkg::IDX_ONE:  idx_sel = pmo_pkg::IDX_W'(1);
         pmo_pkg::IDX_KM1:  idx_sel = pmo_pkg::IDX_W'(seen_ff - pmo_pkg::SEEN_W'(1));
         default:           idx_sel = seen_ff[pmo_pkg::IDX_W-1:0];
      endcase
   end

   always_comb begin
      sts.seen_zero = (seen_ff == '0);
      sts.seen_one  = (seen_ff == pmo_pkg::SEEN_W'(1));
      sts.last      = last_ff;
      sts.ok        = ok_ff;
      sts.norm_done = umax[24];
      sts.sqrt_last = b_ff[0];
      sts.div_last  = (cnt_ff == 5'd31);
      sts.dot_big   = (dot_ff >= 32'(pmo_pkg::DOT_MIN));
      sts.out_free  = !out_v_ff || rsp_tready;
   end

   // arithmetic and window
   always_ff @(posedge clock) begin
      case (cmd.op)
         pmo_pkg::OP_ACCEPT: begin
            cur_x_ff <= req_tdata[CW-1:0];
            cur_y_ff <= req_tdata[2*CW-1:CW];
            last_ff  <= req_tlast;
         end
         pmo_pkg::OP_JOB_START: begin
            ok_ff   <= 1'b1;
            offx_ff <= '0;
            offy_ff <= '0;
         end
         pmo_pkg::OP_U_LOAD: begin
            ux_ff   <= vx[24] ? 25'(-vx) : 25'(vx);
            uy_ff   <= vy[24] ? 25'(-vy) : 25'(vy);
            negx_ff <= vx[24];
            negy_ff <= vy[24];
            ok_ff   <= ok_ff & ((vx != '0) || (vy != '0));
         end
         pmo_pkg::OP_U_NORM: begin
            if (!umax[24]) begin
               ux_ff <= {ux_ff[23:0], 1'b0};
               uy_ff <= {uy_ff[23:0], 1'b0};
            end
         end
         pmo_pkg::OP_U_SQ1: v_ff <= 52'(ux_ff * ux_ff);
         pmo_pkg::OP_U_SQ2: begin
            v_ff <= v_ff + 52'(uy_ff * uy_ff);
            r_ff <= '0;
            b_ff <= 52'(1) << 50;
         end
         pmo_pkg::OP_SQRT_STEP: begin
            if (v_ff >= rb) begin
               v_ff <= v_ff - rb;
               r_ff <= (r_ff >> 1) + b_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            b_ff <= b_ff >> 2;
         end
         pmo_pkg::OP_DX_LOAD: begin
            rem_ff <= (52'(ux_ff) << 14) + (r_ff >> 1);
            den_ff <= {r_ff[29:0], 31'b0};
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         pmo_pkg::OP_DY_LOAD: begin
            qx_ff  <= quo_ff[UW-1:0];
            rem_ff <= (52'(uy_ff) << 14) + (r_ff >> 1);
            den_ff <= {r_ff[29:0], 31'b0};
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         pmo_pkg::OP_MDIV_LOAD: begin
            rem_ff <= (52'(wall_thickness) << 28) + 52'(dot_ff[31:1]);
            den_ff <= {dot_ff[29:0], 31'b0};
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         pmo_pkg::OP_DIV_STEP: begin
            if (rem_ext >= den_ff) begin
               rem_ff <= rem_ff - den_ff[51:0];
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
            den_ff <= den_ff >> 1;
            cnt_ff <= cnt_ff + 5'd1;
         end
         pmo_pkg::OP_U_STORE: begin
            case (cmd.unit)
               2'd0: begin
                  d0x_ff <= qx_s;
                  d0y_ff <= qy_s;
               end
               2'd1: begin
                  d1x_ff <= qx_s;
                  d1y_ff <= qy_s;
               end
               default: begin
                  mx_ff <= qx_s;
                  my_ff <= qy_s;
               end
            endcase
         end
         pmo_pkg::OP_DOT1: dot_ff <= 32'(mx_ff * (-d0y_ff));
         pmo_pkg::OP_DOT2: dot_ff <= dot_ff + 32'(my_ff * d0x_ff);
         pmo_pkg::OP_LEN_DIV: len_ff <= (quo_ff < 32'(wt3)) ? quo_ff[24:0] : wt3;
         pmo_pkg::OP_LEN_WT: len_ff <= 25'(wall_thickness);
         pmo_pkg::OP_SCX: offx_ff <= scale(sc_x, len_ff);
         pmo_pkg::OP_SCY: offy_ff <= scale(sc_y, len_ff);
         pmo_pkg::OP_PUT: begin
            ox_ff    <= sat24(ox_s);
            oy_ff    <= sat24(oy_s);
            ix_ff    <= sat24(ix_s);
            iy_ff    <= sat24(iy_s);
            idx_ff   <= idx_sel;
            degen_ff <= !ok_ff;
            olast_ff <= cmd.job.last;
         end
         pmo_pkg::OP_COMMIT: begin
            if (seen_ff == '0) begin
               first_x_ff <= cur_x_ff;
               first_y_ff <= cur_y_ff;
            end else begin
               if (seen_ff == pmo_pkg::SEEN_W'(1)) begin
                  second_x_ff <= cur_x_ff;
                  second_y_ff <= cur_y_ff;
               end
               older_x_ff <= newer_x_ff;
               older_y_ff <= newer_y_ff;
            end
            newer_x_ff <= cur_x_ff;
            newer_y_ff <= cur_y_ff;
         end
         default: ;
      endcase
   end

   // point count and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (cmd.op == pmo_pkg::OP_COMMIT) begin
            if (last_ff) begin
               seen_ff <= '0;
            end else if (!seen_max) begin
               seen_ff <= seen_ff + pmo_pkg::SEEN_W'(1);
            end
         end
         if (cmd.op == pmo_pkg::OP_PUT) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {idx_ff, iy_ff, ix_ff, oy_ff, ox_ff};
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = degen_ff;

endmodule
`default_nettype wire
